// File: rtl/ldpm_pkg.sv
// Shared types, constants and helper functions for the lens distortion point map.
// No dependencies; every other file in rtl/ except ldpm_fifo imports this package.
package ldpm_pkg;

	localparam int PIX_W      = 16;
	localparam int CFG_F_W    = 24;
	localparam int COEF_W     = 32;
	localparam int OUT_W      = 20;
	localparam int NORM_BITS  = 32;
	localparam int TERM_W     = 48;
	localparam int LDPM_QUEUE_DEPTH = 4;

	// Divider: one input register, one stage per quotient bit, one saturation register.
	localparam int DIV_LATENCY     = NORM_BITS + 2;
	localparam int POST_DIV_STAGES = 15;
	localparam int BACK_LATENCY    = DIV_LATENCY + POST_DIV_STAGES;

	localparam logic signed [TERM_W-1:0] RAD_ONE = TERM_W'(64'd1073741824);

	typedef enum logic [2:0] {
		REG_FOCAL_X, REG_FOCAL_Y, REG_CENTER_X, REG_CENTER_Y,
		REG_RADIAL_K1, REG_RADIAL_K2, REG_RADIAL_K3, REG_TANGENTIAL_PAIR
	} ldpm_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} ldpm_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] mapped_x;
		logic signed [OUT_W-1:0] mapped_y;
		logic                    clipped;
	} ldpm_result_t;

	typedef struct packed {
		logic [CFG_F_W-1:0]       focal_x;
		logic [CFG_F_W-1:0]       focal_y;
		logic [CFG_F_W-1:0]       center_x;
		logic [CFG_F_W-1:0]       center_y;
		logic signed [COEF_W-1:0] k1;
		logic signed [COEF_W-1:0] k2;
		logic signed [COEF_W-1:0] k3;
		logic signed [COEF_W-1:0] p1;
		logic signed [COEF_W-1:0] p2;
	} ldpm_cfg_t;

	// Classified offset from the principal point, one axis.
	typedef struct packed {
		logic [CFG_F_W-1:0] mag;
		logic               neg;
		logic               ovf;
		logic               zero;
	} ldpm_req_t;

	localparam ldpm_cfg_t CFG_RESET = '{
		focal_x:  24'd1254175,
		focal_y:  24'd1254175,
		center_x: 24'd1339666,
		center_y: 24'd824205,
		k1: '0, k2: '0, k3: '0, p1: '0, p2: '0
	};

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] r;
		r = v[31] ? 32'(-v) : 32'(v);
		return r;
	endfunction

	function automatic logic [TERM_W-1:0] mag_term(input logic signed [TERM_W-1:0] v);
		logic [TERM_W-1:0] r;
		r = v[TERM_W-1] ? TERM_W'(-v) : TERM_W'(v);
		return r;
	endfunction

	function automatic logic signed [TERM_W-1:0] apply_sign(input logic neg,
			input logic [TERM_W-2:0] m);
		logic signed [TERM_W-1:0] p;
		p = signed'({1'b0, m});
		return neg ? -p : p;
	endfunction

endpackage

// File: rtl/ldpm_fifo.sv
// Small flop-based queue used between front and back and on the result side.
// Depends on nothing but its parameters.
module ldpm_fifo #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] rd_data,
	output logic             empty
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: rtl/ldpm_front.sv
// Front classifier: offset of each coordinate from the principal point, its sign,
// and early zero and quotient-overflow flags. Depends on ldpm_pkg.
module ldpm_front (
	input  ldpm_pkg::ldpm_item_t item,
	input  ldpm_pkg::ldpm_cfg_t  cfg,
	output ldpm_pkg::ldpm_req_t  req_x,
	output ldpm_pkg::ldpm_req_t  req_y
);
	import ldpm_pkg::*;

	logic [CFG_F_W:0]   dt_x, dt_y, ndt_x, ndt_y;
	logic [CFG_F_W-1:0] mag_x, mag_y;

	// Pixel Q12.4 lifted to Q.12 minus the centre.
	assign dt_x  = {1'b0, item.pixel_x, 8'b0} - {1'b0, cfg.center_x};
	assign dt_y  = {1'b0, item.pixel_y, 8'b0} - {1'b0, cfg.center_y};
	assign ndt_x = -dt_x;
	assign ndt_y = -dt_y;
	assign mag_x = dt_x[CFG_F_W] ? ndt_x[CFG_F_W-1:0] : dt_x[CFG_F_W-1:0];
	assign mag_y = dt_y[CFG_F_W] ? ndt_y[CFG_F_W-1:0] : dt_y[CFG_F_W-1:0];

	// Quotient needs more than 32 bits when mag >= 4 * focal.
	assign req_x.mag  = mag_x;
	assign req_x.neg  = dt_x[CFG_F_W];
	assign req_x.ovf  = ({2'b00, mag_x} >= {cfg.focal_x, 2'b00});
	assign req_x.zero = (mag_x == '0);
	assign req_y.mag  = mag_y;
	assign req_y.neg  = dt_y[CFG_F_W];
	assign req_y.ovf  = ({2'b00, mag_y} >= {cfg.focal_y, 2'b00});
	assign req_y.zero = (mag_y == '0);

endmodule

// File: rtl/ldpm_div.sv
// Pipelined restoring divider: (mag << 30) / focal, one quotient bit per stage,
// saturated to signed Q2.30. Depends on ldpm_pkg.
module ldpm_div (
	input  logic                         clk,
	input  logic                         en,
	input  ldpm_pkg::ldpm_req_t          req,
	input  logic [ldpm_pkg::CFG_F_W-1:0] divisor,
	output logic signed [31:0]           quot,
	output logic                         sat
);
	import ldpm_pkg::*;

	logic [CFG_F_W-1:0]   rem_s [NORM_BITS+1];
	logic [NORM_BITS-1:0] quo_s [NORM_BITS+1];
	logic [1:0]           low_s [NORM_BITS+1];
	logic [NORM_BITS:0]   neg_s, ovf_s, zero_s;

	logic [NORM_BITS-1:0] q_fin, q_lim;
	logic                 over;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= {2'b00, req.mag[CFG_F_W-1:2]};
			low_s[0]  <= req.mag[1:0];
			quo_s[0]  <= '0;
			neg_s[0]  <= req.neg;
			ovf_s[0]  <= req.ovf;
			zero_s[0] <= req.zero;
		end
	end

	for (genvar i = 1; i <= NORM_BITS; i++) begin : g_step
		logic [CFG_F_W:0]   trial;
		logic [CFG_F_W+1:0] diff;

		assign trial = {rem_s[i-1], low_s[i-1][1]};
		assign diff  = {1'b0, trial} - {2'b00, divisor};

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[CFG_F_W+1]) begin
					rem_s[i] <= diff[CFG_F_W-1:0];
					quo_s[i] <= {quo_s[i-1][NORM_BITS-2:0], 1'b1};
				end else begin
					rem_s[i] <= trial[CFG_F_W-1:0];
					quo_s[i] <= {quo_s[i-1][NORM_BITS-2:0], 1'b0};
				end
				low_s[i]  <= {low_s[i-1][0], 1'b0};
				neg_s[i]  <= neg_s[i-1];
				ovf_s[i]  <= ovf_s[i-1];
				zero_s[i] <= zero_s[i-1];
			end
		end
	end

	// Negative side reaches 2^31, positive side stops at 2^31 - 1.
	assign over  = ovf_s[NORM_BITS] || (neg_s[NORM_BITS] ?
		(quo_s[NORM_BITS] > 32'h8000_0000) : quo_s[NORM_BITS][31]);
	assign q_lim = neg_s[NORM_BITS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign q_fin = zero_s[NORM_BITS] ? '0 : (over ? q_lim : quo_s[NORM_BITS]);

	always_ff @(posedge clk) begin
		if (en) begin
			quot <= neg_s[NORM_BITS] ? signed'(-q_fin) : signed'(q_fin);
			sat  <= !zero_s[NORM_BITS] && over;
		end
	end

endmodule

// File: rtl/ldpm_back.sv
// Back end: normalising dividers, radial and tangential polynomial, rescale to pixels,
// rounding and saturation. Depends on ldpm_pkg and ldpm_div.
module ldpm_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ldpm_pkg::ldpm_cfg_t    cfg,
	input  logic                   req_empty,
	input  ldpm_pkg::ldpm_req_t    req_x,
	input  ldpm_pkg::ldpm_req_t    req_y,
	output logic                   req_pop,
	input  logic                   res_full,
	output logic                   res_push,
	output ldpm_pkg::ldpm_result_t res_data
);
	import ldpm_pkg::*;

	logic                    en;
	logic [BACK_LATENCY-1:0] vld_q;

	logic signed [31:0] x_s0, y_s0;
	logic               satx_s0, saty_s0;
	logic [31:0]        km1, km2, km3, pm1, pm2;

	// S1..S3
	logic [63:0]        xx_s1, yy_s1, xyp_s1;
	logic               xyneg_s1, xyneg_s2, xyneg_s3, xyneg_s4;
	logic signed [31:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4, x_s5, y_s5;
	logic signed [31:0] x_s6, y_s6, x_s7, y_s7, x_s8, y_s8, x_s9, y_s9;
	logic               clip_s1, clip_s2, clip_s3, clip_s4, clip_s5, clip_s6, clip_s7;
	logic               clip_s8, clip_s9, clip_s10, clip_s11, clip_s12, clip_s13;
	logic               clip_s14, clip_s15;
	logic [63:0]        r2sum;
	logic [32:0]        x2_s2, y2_s2, xym_s2, xym_s3;
	logic [33:0]        r2_s2, r2_s3, r2_s4;
	logic [67:0]        r2sq_s3;
	logic [65:0]        k1p_s3;
	logic [34:0]        tx_s3, ty_s3;

	// S4..S9
	logic [36:0]        r4_s4;
	logic signed [TERM_W-1:0] k1t_s4, k1t_s5, k1t_s6, k1t_s7, k1t_s8;
	logic [64:0]        pxy1_s4, pxy2_s4;
	logic [66:0]        ptx_s4, pty_s4;
	logic [52:0]        r6a_s5;
	logic [51:0]        r6b_s5;
	logic [68:0]        k2p_s5;
	logic signed [TERM_W-1:0] t1x, t2x, t1y, t2y;
	logic signed [TERM_W-1:0] tangx_s5, tangy_s5, tangx_s6, tangy_s6, tangx_s7, tangy_s7;
	logic signed [TERM_W-1:0] tangx_s8, tangy_s8, tangx_s9, tangy_s9, tangx_s10, tangy_s10;
	logic signed [TERM_W-1:0] tangx_s11, tangy_s11;
	logic [71:0]        r6sum;
	logic [39:0]        r6_s6;
	logic signed [TERM_W-1:0] k2t_s6, k2t_s7, k2t_s8;
	logic [51:0]        k3a_s7, k3b_s7;
	logic [71:0]        k3sum;
	logic signed [TERM_W-1:0] k3t_s8, rad_s9;

	// S10..S15
	logic [TERM_W-1:0]  radm;
	logic [31:0]        mx9, my9;
	logic [54:0]        xra_s10, xrb_s10, yra_s10, yrb_s10;
	logic               xrneg_s10, yrneg_s10;
	logic [77:0]        xrsum, yrsum;
	logic signed [TERM_W-1:0] xr_s11, yr_s11, xd_s12, yd_s12;
	logic [TERM_W-1:0]  xdm, ydm;
	logic [46:0]        xfa_s13, xfb_s13, yfa_s13, yfb_s13;
	logic               xfneg_s13, yfneg_s13;
	logic [69:0]        xfsum, yfsum;
	logic signed [TERM_W-1:0] vx_s14, vy_s14, sumx, sumy;
	logic signed [TERM_W-9:0] wx_s15, wy_s15;
	logic               hix, lox, hiy, loy;

	// Advance everything unless a finished result has nowhere to go.
	assign en       = !(vld_q[BACK_LATENCY-1] && res_full);
	assign req_pop  = en && !req_empty;
	assign res_push = en && vld_q[BACK_LATENCY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[BACK_LATENCY-2:0], !req_empty};
		end
	end

	ldpm_div u_div_x (
		.clk(clk), .en(en), .req(req_x), .divisor(cfg.focal_x), .quot(x_s0), .sat(satx_s0)
	);
	ldpm_div u_div_y (
		.clk(clk), .en(en), .req(req_y), .divisor(cfg.focal_y), .quot(y_s0), .sat(saty_s0)
	);

	assign km1 = mag32(cfg.k1);
	assign km2 = mag32(cfg.k2);
	assign km3 = mag32(cfg.k3);
	assign pm1 = mag32(cfg.p1);
	assign pm2 = mag32(cfg.p2);

	assign r2sum = xx_s1 + yy_s1;
	assign t1x   = apply_sign(cfg.p1[31] ^ xyneg_s4, (TERM_W-1)'(pxy1_s4[64:28]));
	assign t2x   = apply_sign(cfg.p2[31], (TERM_W-1)'(ptx_s4[66:28]));
	assign t1y   = apply_sign(cfg.p1[31], (TERM_W-1)'(pty_s4[66:28]));
	assign t2y   = apply_sign(cfg.p2[31] ^ xyneg_s4, (TERM_W-1)'(pxy2_s4[64:28]));
	assign r6sum = {1'b0, r6a_s5, 18'b0} + 72'(r6b_s5);
	assign k3sum = {k3a_s7, 20'b0} + 72'(k3b_s7);
	assign radm  = mag_term(rad_s9);
	assign mx9   = mag32(x_s9);
	assign my9   = mag32(y_s9);
	assign xrsum = {xra_s10, 23'b0} + 78'(xrb_s10);
	assign yrsum = {yra_s10, 23'b0} + 78'(yrb_s10);
	assign xdm   = mag_term(xd_s12);
	assign ydm   = mag_term(yd_s12);
	assign xfsum = {xfa_s13, 23'b0} + 70'(xfb_s13);
	assign yfsum = {yfa_s13, 23'b0} + 70'(yfb_s13);
	assign sumx  = vx_s14 + signed'({{(TERM_W-CFG_F_W){1'b0}}, cfg.center_x})
		+ TERM_W'(128);
	assign sumy  = vy_s14 + signed'({{(TERM_W-CFG_F_W){1'b0}}, cfg.center_y})
		+ TERM_W'(128);

	always_ff @(posedge clk) begin
		if (en) begin
			// S1: squares and cross product of the normalised point
			xx_s1    <= mag32(x_s0) * mag32(x_s0);
			yy_s1    <= mag32(y_s0) * mag32(y_s0);
			xyp_s1   <= mag32(x_s0) * mag32(y_s0);
			xyneg_s1 <= x_s0[31] ^ y_s0[31];
			x_s1     <= x_s0;
			y_s1     <= y_s0;
			clip_s1  <= satx_s0 | saty_s0;
			// S2: back to Q.30
			x2_s2    <= xx_s1[62:30];
			y2_s2    <= yy_s1[62:30];
			r2_s2    <= r2sum[63:30];
			xym_s2   <= xyp_s1[62:30];
			xyneg_s2 <= xyneg_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			clip_s2  <= clip_s1;
			// S3
			r2sq_s3  <= r2_s2 * r2_s2;
			k1p_s3   <= km1 * r2_s2;
			tx_s3    <= 35'(r2_s2) + {1'b0, x2_s2, 1'b0};
			ty_s3    <= 35'(r2_s2) + {1'b0, y2_s2, 1'b0};
			r2_s3    <= r2_s2;
			xym_s3   <= xym_s2;
			xyneg_s3 <= xyneg_s2;
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			clip_s3  <= clip_s2;
			// S4
			r4_s4    <= r2sq_s3[66:30];
			k1t_s4   <= apply_sign(cfg.k1[31], (TERM_W-1)'(k1p_s3[65:28]));
			pxy1_s4  <= pm1 * xym_s3;
			pxy2_s4  <= pm2 * xym_s3;
			ptx_s4   <= pm2 * tx_s3;
			pty_s4   <= pm1 * ty_s3;
			r2_s4    <= r2_s3;
			xyneg_s4 <= xyneg_s3;
			x_s4     <= x_s3;
			y_s4     <= y_s3;
			clip_s4  <= clip_s3;
			// S5: r6 split in two partial products
			r6a_s5   <= r4_s4[36:18] * r2_s4;
			r6b_s5   <= r4_s4[17:0] * r2_s4;
			k2p_s5   <= km2 * r4_s4;
			tangx_s5 <= t1x + t1x + t2x;
			tangy_s5 <= t1y + t2y + t2y;
			k1t_s5   <= k1t_s4;
			x_s5     <= x_s4;
			y_s5     <= y_s4;
			clip_s5  <= clip_s4;
			// S6
			r6_s6    <= r6sum[69:30];
			k2t_s6   <= apply_sign(cfg.k2[31], (TERM_W-1)'(k2p_s5[68:28]));
			k1t_s6   <= k1t_s5;
			tangx_s6 <= tangx_s5;
			tangy_s6 <= tangy_s5;
			x_s6     <= x_s5;
			y_s6     <= y_s5;
			clip_s6  <= clip_s5;
			// S7
			k3a_s7   <= km3 * r6_s6[39:20];
			k3b_s7   <= km3 * r6_s6[19:0];
			k1t_s7   <= k1t_s6;
			k2t_s7   <= k2t_s6;
			tangx_s7 <= tangx_s6;
			tangy_s7 <= tangy_s6;
			x_s7     <= x_s6;
			y_s7     <= y_s6;
			clip_s7  <= clip_s6;
			// S8
			k3t_s8   <= apply_sign(cfg.k3[31], (TERM_W-1)'(k3sum[71:28]));
			k1t_s8   <= k1t_s7;
			k2t_s8   <= k2t_s7;
			tangx_s8 <= tangx_s7;
			tangy_s8 <= tangy_s7;
			x_s8     <= x_s7;
			y_s8     <= y_s7;
			clip_s8  <= clip_s7;
			// S9: radial factor
			rad_s9   <= RAD_ONE + k1t_s8 + k2t_s8 + k3t_s8;
			tangx_s9 <= tangx_s8;
			tangy_s9 <= tangy_s8;
			x_s9     <= x_s8;
			y_s9     <= y_s8;
			clip_s9  <= clip_s8;
			// S10
			xra_s10   <= mx9 * radm[45:23];
			xrb_s10   <= mx9 * radm[22:0];
			yra_s10   <= my9 * radm[45:23];
			yrb_s10   <= my9 * radm[22:0];
			xrneg_s10 <= x_s9[31] ^ rad_s9[TERM_W-1];
			yrneg_s10 <= y_s9[31] ^ rad_s9[TERM_W-1];
			tangx_s10 <= tangx_s9;
			tangy_s10 <= tangy_s9;
			clip_s10  <= clip_s9;
			// S11
			xr_s11    <= apply_sign(xrneg_s10, (TERM_W-1)'(xrsum[77:30]));
			yr_s11    <= apply_sign(yrneg_s10, (TERM_W-1)'(yrsum[77:30]));
			tangx_s11 <= tangx_s10;
			tangy_s11 <= tangy_s10;
			clip_s11  <= clip_s10;
			// S12: distorted normalised point
			xd_s12    <= xr_s11 + tangx_s11;
			yd_s12    <= yr_s11 + tangy_s11;
			clip_s12  <= clip_s11;
			// S13: rescale by focal length
			xfa_s13   <= xdm[45:23] * cfg.focal_x;
			xfb_s13   <= xdm[22:0] * cfg.focal_x;
			yfa_s13   <= ydm[45:23] * cfg.focal_y;
			yfb_s13   <= ydm[22:0] * cfg.focal_y;
			xfneg_s13 <= xd_s12[TERM_W-1];
			yfneg_s13 <= yd_s12[TERM_W-1];
			clip_s13  <= clip_s12;
			// S14
			vx_s14    <= apply_sign(xfneg_s13, (TERM_W-1)'(xfsum[69:30]));
			vy_s14    <= apply_sign(yfneg_s13, (TERM_W-1)'(yfsum[69:30]));
			clip_s14  <= clip_s13;
			// S15: add centre, round half up to Q.4
			wx_s15    <= (TERM_W-8)'(sumx >>> 8);
			wy_s15    <= (TERM_W-8)'(sumy >>> 8);
			clip_s15  <= clip_s14;
		end
	end

	assign hix = !wx_s15[TERM_W-9] && (|wx_s15[TERM_W-10:OUT_W-1]);
	assign lox = wx_s15[TERM_W-9] && !(&wx_s15[TERM_W-10:OUT_W-1]);
	assign hiy = !wy_s15[TERM_W-9] && (|wy_s15[TERM_W-10:OUT_W-1]);
	assign loy = wy_s15[TERM_W-9] && !(&wy_s15[TERM_W-10:OUT_W-1]);

	always_comb begin
		priority if (hix) begin
			res_data.mapped_x = {1'b0, {(OUT_W-1){1'b1}}};
		end else if (lox) begin
			res_data.mapped_x = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			res_data.mapped_x = wx_s15[OUT_W-1:0];
		end
		priority if (hiy) begin
			res_data.mapped_y = {1'b0, {(OUT_W-1){1'b1}}};
		end else if (loy) begin
			res_data.mapped_y = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			res_data.mapped_y = wy_s15[OUT_W-1:0];
		end
		res_data.clipped = clip_s15 | hix | lox | hiy | loy;
	end

endmodule

// File: rtl/lens_distortion_point_map.sv
// Top level of the lens distortion point map: configuration registers, front
// classifier, front queue, back pipeline and result queue. Uses all of rtl/.
//
// Usage: write the eight configuration registers through wr_en / wr_index /
// wr_data while the block is idle; a write lands at the clock edge where wr_en
// is high. Pixel coordinates (Q12.4) enter through a queue-style port: a
// transaction completes when push is high and full is low. Results leave the
// same way: the oldest result sits on result while empty is low and is taken
// at an edge where pop is high.
// Throughput is one transaction per clock in each direction while no stall
// holds the back pipeline. An accepted input passes through the front queue,
// the bit-per-stage normalising divider and the polynomial and rescale
// pipeline, then the result queue, before its result shows on the output.
// When the receiver stalls, results build up in the result queue; once the
// last pipeline stage holds a result that cannot be written, the whole back
// pipeline holds, the front queue fills and full rises. Nothing is dropped.
// Reset (arst_n low) empties both queues, clears every valid bit and loads the
// default camera intrinsics with zero distortion coefficients.
module lens_distortion_point_map #(
	parameter int QueueDepth = ldpm_pkg::LDPM_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [2:0]             wr_index,
	input  logic [63:0]            wr_data,
	input  logic                   push,
	input  ldpm_pkg::ldpm_item_t   item,
	output logic                   full,
	input  logic                   pop,
	output ldpm_pkg::ldpm_result_t result,
	output logic                   empty
);
	import ldpm_pkg::*;

	localparam int ReqW = 2 * $bits(ldpm_req_t);
	localparam int ResW = $bits(ldpm_result_t);

	ldpm_cfg_t    cfg_q;
	ldpm_req_t    cls_x, cls_y, req_x, req_y;
	logic         req_empty, req_pop;
	logic         res_full, res_push;
	ldpm_result_t res_data;

	// Configuration registers; unused high bits of narrow registers are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (ldpm_reg_t'(wr_index))
				REG_FOCAL_X:         cfg_q.focal_x  <= wr_data[CFG_F_W-1:0];
				REG_FOCAL_Y:         cfg_q.focal_y  <= wr_data[CFG_F_W-1:0];
				REG_CENTER_X:        cfg_q.center_x <= wr_data[CFG_F_W-1:0];
				REG_CENTER_Y:        cfg_q.center_y <= wr_data[CFG_F_W-1:0];
				REG_RADIAL_K1:       cfg_q.k1       <= signed'(wr_data[31:0]);
				REG_RADIAL_K2:       cfg_q.k2       <= signed'(wr_data[31:0]);
				REG_RADIAL_K3:       cfg_q.k3       <= signed'(wr_data[31:0]);
				REG_TANGENTIAL_PAIR: begin
					cfg_q.p1 <= signed'(wr_data[31:0]);
					cfg_q.p2 <= signed'(wr_data[63:32]);
				end
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Classify on the way in so the queue holds ready-made divider requests.
	ldpm_front u_front (
		.item(item), .cfg(cfg_q), .req_x(cls_x), .req_y(cls_y)
	);

	ldpm_fifo #(.Width(ReqW), .Depth(QueueDepth)) u_req_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wr_data({cls_x, cls_y}), .full(full),
		.pop(req_pop), .rd_data({req_x, req_y}), .empty(req_empty)
	);

	ldpm_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.req_empty(req_empty), .req_x(req_x), .req_y(req_y), .req_pop(req_pop),
		.res_full(res_full), .res_push(res_push), .res_data(res_data)
	);

	// Result queue: lets the back keep moving while a result waits.
	ldpm_fifo #(.Width(ResW), .Depth(QueueDepth)) u_res_queue (
		.clk(clk), .arst_n(arst_n),
		.push(res_push), .wr_data(res_data), .full(res_full),
		.pop(pop), .rd_data(result), .empty(empty)
	);

endmodule
